>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks, the trainer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/lrsgd_pkg.sv
// Types, codes and saturation helpers for the linear regression trainer.
package lrsgd_pkg;

  // Request codes
  localparam logic [1:0] REQ_TRAIN = 2'd0;
  localparam logic [1:0] REQ_EVAL  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_ERROR  = 2'd0;
  localparam logic [1:0] KIND_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_COST   = 2'd2;

  // Configuration register indexes
  localparam logic REG_LEARNING_RATE = 1'b0;
  localparam logic REG_FEATURE_COUNT = 1'b1;

  localparam logic [15:0] LEARNING_RATE_RESET = 16'd655;
  localparam logic [4:0]  FEATURE_COUNT_RESET = 5'd1;

  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
  // 1.0 in Q16.16, the bias cell's feature
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [31:0]  sample_value;
  } sample_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [4:0]          weight_index;
    logic signed [47:0]  result_value;
    logic                last_result;
  } result_t;

  // Update token handed along the cell row: gradient split at bit 16
  typedef struct packed {
    logic                valid;
    logic signed [31:0]  grad_hi;
    logic [15:0]         grad_lo;
  } token_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
      r = v[47:0];
    end else if (v[49]) begin
      r = MIN48;
    end else begin
      r = MAX48;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v[65:31] == '0 || v[65:31] == '1) begin
      r = v[31:0];
    end else if (v[65]) begin
      r = MIN32;
    end else begin
      r = MAX32;
    end
    return r;
  endfunction

endpackage

>>> rtl/lrsgd_cell.sv
// One weight cell: holds a weight and its buffered feature, applies the update token.
module lrsgd_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 unit_feature,
  input  logic                 enable,
  input  logic                 clear,
  input  logic                 feat_write,
  input  logic signed [31:0]   feat_value,
  input  lrsgd_pkg::token_t    tok_in,
  output lrsgd_pkg::token_t    tok_out,
  output logic signed [31:0]   weight
);

  logic signed [31:0] feature;
  logic signed [31:0] fsel;
  logic signed [16:0] grad_lo_s;
  logic signed [63:0] hi_full;
  logic signed [48:0] lo_full;
  logic               prod_valid;
  logic signed [63:0] prod_hi;
  logic signed [48:0] prod_lo;
  logic signed [64:0] step;
  logic signed [65:0] diff;

  // Feature buffer entry, written while the sample streams in
  always_ff @(posedge clk) begin
    if (feat_write) begin
      feature <= feat_value;
    end
  end

  // Products of the gradient halves with the feature
  assign fsel      = unit_feature ? lrsgd_pkg::ONE_Q16 : feature;
  assign grad_lo_s = $signed({1'b0, tok_in.grad_lo});
  assign hi_full   = tok_in.grad_hi * fsel;
  assign lo_full   = grad_lo_s * fsel;

  always_ff @(posedge clk) begin
    prod_hi <= hi_full;
    prod_lo <= lo_full;
  end

  // Token moves one cell per cycle; product stage flags the update
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      prod_valid    <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      prod_valid    <= tok_in.valid && enable;
    end
    tok_out.grad_hi <= tok_in.grad_hi;
    tok_out.grad_lo <= tok_in.grad_lo;
  end

  // Weight step: floor(grad * feature / 2^16), then saturating subtract
  assign step = {prod_hi[63], prod_hi} + {{32{prod_lo[48]}}, prod_lo[48:16]};
  assign diff = {{34{weight[31]}}, weight} - {step[64], step};

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      weight <= '0;
    end else if (prod_valid) begin
      weight <= lrsgd_pkg::sat32(diff);
    end
  end

endmodule

>>> rtl/linear_regression_sgd_trainer_top.sv
// Top level of the linear regression SGD trainer: control, accumulators, cell row.
//
// Sample channel (sample_valid/sample_stall/sample) carries one element per
// transaction: feature_count features, then the target. req_type picks train
// or evaluate on the target, read-out of weights and cost, or clear.
// Result channel (result_valid/result_stall/result) returns the prediction
// error for each target, or count+1 weights (bias first) then the cost for a
// read; last_result marks the final one.
// One transaction is handled at a time. A feature element goes through
// weight select and multiply, then accumulate. A target goes through
// prediction, error and output, then the update token walks the cell
// row (train) or the cost is accumulated (evaluate). A read returns the
// weights, then the cost; clear is done while the block stays idle.
// The result register decouples the sides: a waiting result does not block
// new transactions, but producing a result waits while a held result is stalled.
// Synchronous reset zeroes weights, cost and the sample position, and sets
// learning_rate to 655, feature_count to 1. The block does not check that the
// user writes configuration via cfg_write/cfg_index/cfg_data only while it is idle.
module linear_regression_sgd_trainer_top #(
  parameter int MAX_FEATURES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  lrsgd_pkg::sample_t  sample,
  output logic                result_valid,
  input  logic                result_stall,
  output lrsgd_pkg::result_t  result
);

  `include "assert_macros.svh"

  localparam int IW = $clog2(MAX_FEATURES + 1);
  localparam int UW = $clog2(MAX_FEATURES + 2);
  localparam int NCELL = MAX_FEATURES + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_PRED = 4'd2;
  localparam logic [3:0] S_ERR  = 4'd3;
  localparam logic [3:0] S_OUT  = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_COST = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_RDC  = 4'd8;

  logic [3:0]          state;
  logic [15:0]         learning_rate;
  logic [4:0]          feature_count;
  logic [IW-1:0]       n_eff;
  logic [IW-1:0]       n_q;
  logic [IW-1:0]       pos;
  logic [IW-1:0]       rd_idx;
  logic [IW-1:0]       sel_idx;
  logic [UW-1:0]       upd_cnt;
  logic signed [47:0]  psum;
  logic signed [47:0]  cost;
  logic signed [63:0]  prod_q;
  logic signed [31:0]  x_q;
  logic                train_q;
  logic signed [47:0]  pred_q;
  logic signed [47:0]  err_q;
  logic signed [64:0]  g_full;
  logic signed [47:0]  g_q;
  logic [47:0]         mag;
  logic [63:0]         sq_full;
  logic [47:0]         sq_q;
  logic                in_acc;
  logic                is_target;
  logic                feat_acc;
  logic                out_free;
  logic                load;
  lrsgd_pkg::result_t  load_data;
  logic signed [31:0]  w_all [0:MAX_FEATURES];
  logic signed [31:0]  w_sel;
  lrsgd_pkg::token_t   tok_chain [0:MAX_FEATURES];
  lrsgd_pkg::token_t   tok_end;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= lrsgd_pkg::LEARNING_RATE_RESET;
      feature_count <= lrsgd_pkg::FEATURE_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lrsgd_pkg::REG_LEARNING_RATE: learning_rate <= cfg_data;
        lrsgd_pkg::REG_FEATURE_COUNT: feature_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Feature count in effect, clamped to 1..MAX_FEATURES
  always_comb begin
    if (feature_count == '0) begin
      n_eff = IW'(1);
    end else if (int'(feature_count) > MAX_FEATURES) begin
      n_eff = IW'(MAX_FEATURES);
    end else begin
      n_eff = IW'(feature_count);
    end
  end

  assign sample_stall = (state != S_IDLE);
  assign in_acc       = sample_valid && !sample_stall;
  assign is_target    = (pos >= n_eff);
  assign feat_acc     = in_acc && !is_target &&
                        (sample.req_type == lrsgd_pkg::REQ_TRAIN ||
                         sample.req_type == lrsgd_pkg::REQ_EVAL);

  // Single weight read port: read-out index or the next feature's weight
  assign sel_idx = (state == S_RD) ? rd_idx : pos + IW'(1);
  assign w_sel   = w_all[sel_idx];

  // Arithmetic feeding the pipeline registers
  assign g_full  = $signed({1'b0, learning_rate}) * err_q;
  assign mag     = err_q[47] ? 48'(-err_q) : 48'(err_q);
  assign sq_full = mag[31:0] * mag[31:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prod_q  <= w_sel * sample.sample_value;
      x_q     <= sample.sample_value;
      train_q <= (sample.req_type == lrsgd_pkg::REQ_TRAIN);
      n_q     <= n_eff;
    end
    if (state == S_PRED) begin
      pred_q <= lrsgd_pkg::sat48({{2{psum[47]}}, psum} + {{18{w_all[0][31]}}, w_all[0]});
    end
    if (state == S_ERR) begin
      err_q <= lrsgd_pkg::sat48({{2{pred_q[47]}}, pred_q} - {{18{x_q[31]}}, x_q});
    end
    if (state == S_OUT) begin
      g_q  <= g_full[63:16];
      sq_q <= (mag[47:32] != '0) ? 48'(lrsgd_pkg::MAX48) : sq_full[63:16];
    end
  end

  // Sequencer and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      psum    <= '0;
      cost    <= '0;
      rd_idx  <= '0;
      upd_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (sample.req_type)
              lrsgd_pkg::REQ_READ: begin
                rd_idx <= '0;
                state  <= S_RD;
              end
              lrsgd_pkg::REQ_CLEAR: begin
                cost <= '0;
                psum <= '0;
                pos  <= '0;
              end
              default: begin
                if (is_target) begin
                  pos   <= '0;
                  state <= S_PRED;
                end else begin
                  pos   <= pos + IW'(1);
                  state <= S_ACC;
                end
              end
            endcase
          end
        end
        S_ACC: begin
          psum  <= lrsgd_pkg::sat48({{2{psum[47]}}, psum} +
                                    {{2{prod_q[63]}}, prod_q[63:16]});
          state <= S_IDLE;
        end
        S_PRED: begin
          psum  <= '0;
          state <= S_ERR;
        end
        S_ERR: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            upd_cnt <= '0;
            state   <= train_q ? S_UPD : S_COST;
          end
        end
        S_UPD: begin
          if (upd_cnt == UW'(MAX_FEATURES + 1)) begin
            state <= S_IDLE;
          end else begin
            upd_cnt <= upd_cnt + UW'(1);
          end
        end
        S_COST: begin
          cost  <= lrsgd_pkg::sat48({2'b00, cost} + {2'b00, sq_q});
          state <= S_IDLE;
        end
        S_RD: begin
          if (out_free) begin
            if (rd_idx == n_q) begin
              state <= S_RDC;
            end else begin
              rd_idx <= rd_idx + IW'(1);
            end
          end
        end
        S_RDC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result selection
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    load                   = 1'b0;
    load_data.result_kind  = lrsgd_pkg::KIND_ERROR;
    load_data.weight_index = '0;
    load_data.result_value = err_q;
    load_data.last_result  = 1'b1;
    case (state)
      S_OUT: begin
        load = out_free;
      end
      S_RD: begin
        load                   = out_free;
        load_data.result_kind  = lrsgd_pkg::KIND_WEIGHT;
        load_data.weight_index = 5'(rd_idx);
        load_data.result_value = {{16{w_sel[31]}}, w_sel};
        load_data.last_result  = 1'b0;
      end
      S_RDC: begin
        load                   = out_free;
        load_data.result_kind  = lrsgd_pkg::KIND_COST;
        load_data.result_value = cost;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_data;
    end
  end

  // Update token enters the bias cell on the first update cycle
  assign tok_chain[0].valid   = (state == S_UPD) && (upd_cnt == '0);
  assign tok_chain[0].grad_hi = g_q[47:16];
  assign tok_chain[0].grad_lo = g_q[15:0];

  // Cell row: cell 0 is the bias, cell k holds weight k and feature k-1
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic fw;
    if (k == 0) begin : g_bias
      assign fw = 1'b0;
    end else begin : g_feat
      assign fw = feat_acc && (pos == IW'(k - 1));
    end

    if (k < MAX_FEATURES) begin : g_mid
      lrsgd_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .unit_feature (k == 0),
        .enable       (n_q >= IW'(k)),
        .clear        (in_acc && sample.req_type == lrsgd_pkg::REQ_CLEAR),
        .feat_write   (fw),
        .feat_value   (sample.sample_value),
        .tok_in       (tok_chain[k]),
        .tok_out      (tok_chain[k+1]),
        .weight       (w_all[k])
      );
    end else begin : g_last
      lrsgd_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .unit_feature (k == 0),
        .enable       (n_q >= IW'(k)),
        .clear        (in_acc && sample.req_type == lrsgd_pkg::REQ_CLEAR),
        .feat_write   (fw),
        .feat_value   (sample.sample_value),
        .tok_in       (tok_chain[k]),
        .tok_out      (tok_end),
        .weight       (w_all[k])
      );
    end
  end

  // Checks
  `ASSERT_IMPLY(a_tok_in_upd, tok_end.valid, state == S_UPD, "token left row outside update")
  `ASSERT_ALWAYS(a_pos_bound, pos <= IW'(MAX_FEATURES), "sample position beyond feature limit")
  `ASSERT_IMPLY(a_rd_bound, state == S_RD, rd_idx <= n_q, "read index beyond feature count")

endmodule
